// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);

`endif

// File: sv/prd_pkg.sv
package prd_pkg;

    localparam int PIX_W          = 8;
    localparam int RADIUS_W       = 4;
    localparam int OUT_W          = 16;
    localparam int FRAC_W         = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 4;
    localparam int DEF_MAX_RADIUS = 15;
    localparam int RADIUS_LIMIT   = (1 << RADIUS_W) - 1;
    localparam int SQ_MAX         = ((1 << PIX_W) - 1) * ((1 << PIX_W) - 1);
    localparam int NUM_CHANNELS   = 3;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1);
    localparam logic                MODE_RST   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_RADIUS = 2'd0,
        REG_COLOUR_MODE   = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic accept;     // pixel pair request taken this cycle
        logic div_step;
        logic root_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic last_pixel;
        logic out_free;
    } status_t;

    function automatic int eff_max(input int max_radius);
        return (max_radius < RADIUS_LIMIT) ? max_radius : RADIUS_LIMIT;
    endfunction

    function automatic int pix_max(input int max_radius);
        return (2 * eff_max(max_radius) + 1) * (2 * eff_max(max_radius) + 1);
    endfunction

    function automatic int sum_w(input int max_radius);
        return $clog2(pix_max(max_radius) * NUM_CHANNELS * SQ_MAX + 1);
    endfunction

    // root width; numerator is padded to twice this so it splits into bit pairs
    function automatic int root_w(input int max_radius);
        return (sum_w(max_radius) + 2 * FRAC_W + 1) / 2;
    endfunction

    function automatic int num_w(input int max_radius);
        return 2 * root_w(max_radius);
    endfunction

endpackage

// File: sv/patch_rms_difference.sv
// channel   | direction | handshake              | payload
// pixel     | in        | pixel_valid/pixel_stall | first_c0..2, second_c0..2
// rms       | out       | rms_valid/rms_stall     | rms_fixed
// cfg       | in        | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// Pixel pairs are taken one per cycle while a window accumulates.
// The last pixel of a window starts the serial divider and then the bit-pair
// square root, and then the result register is loaded: pixel_stall stays high
// until the result register is loaded.
// A result waiting on rms_stall blocks the next window only at its end.
// Reset (rst_n, async) sets radius 1, colour mode on and empty accumulators.
module patch_rms_difference #(
    parameter int MAX_RADIUS = prd_pkg::DEF_MAX_RADIUS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [prd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             pixel_valid,
    output logic                             pixel_stall,
    input  logic [prd_pkg::PIX_W-1:0]        first_c0,
    input  logic [prd_pkg::PIX_W-1:0]        first_c1,
    input  logic [prd_pkg::PIX_W-1:0]        first_c2,
    input  logic [prd_pkg::PIX_W-1:0]        second_c0,
    input  logic [prd_pkg::PIX_W-1:0]        second_c1,
    input  logic [prd_pkg::PIX_W-1:0]        second_c2,
    output logic                             rms_valid,
    input  logic                             rms_stall,
    output logic [prd_pkg::OUT_W-1:0]        rms_fixed
);

    prd_pkg::cmd_t    cmd;
    prd_pkg::status_t status;

    assign cfg_ready = 1'b1;

    prd_ctrl #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .status      (status),
        .pixel_stall (pixel_stall),
        .cmd         (cmd)
    );

    prd_datapath #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .first_c0  (first_c0),
        .first_c1  (first_c1),
        .first_c2  (first_c2),
        .second_c0 (second_c0),
        .second_c1 (second_c1),
        .second_c2 (second_c2),
        .cmd       (cmd),
        .status    (status),
        .rms_stall (rms_stall),
        .rms_valid (rms_valid),
        .rms_fixed (rms_fixed)
    );

endmodule

// File: sv/prd_ctrl.sv
`include "assert_macros.svh"

module prd_ctrl #(
    parameter int MAX_RADIUS = prd_pkg::DEF_MAX_RADIUS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    input  prd_pkg::status_t status,
    output logic             pixel_stall,
    output prd_pkg::cmd_t    cmd
);

    localparam int NUM_W  = prd_pkg::num_w(MAX_RADIUS);
    localparam int ROOT_W = prd_pkg::root_w(MAX_RADIUS);
    localparam int ITER_W = $clog2(NUM_W);

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIVIDE,
        ST_ROOT,
        ST_OUTPUT
    } state_t;

    state_t              state_reg, state_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic                stall_reg, stall_next;

    always_comb
    begin
        cmd.accept    = pixel_valid && !stall_reg;
        cmd.div_step  = (state_reg == ST_DIVIDE);
        cmd.root_step = (state_reg == ST_ROOT);
        cmd.load_out  = (state_reg == ST_OUTPUT) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                if (cmd.accept && status.last_pixel)
                begin
                    state_next = ST_DIVIDE;
                    iter_next  = '0;
                end
            end
            ST_DIVIDE:
            begin
                if (iter_reg == ITER_W'(NUM_W - 1))
                begin
                    state_next = ST_ROOT;
                    iter_next  = '0;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_ROOT:
            begin
                if (iter_reg == ITER_W'(ROOT_W - 1))
                begin
                    state_next = ST_OUTPUT;
                    iter_next  = '0;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_OUTPUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
                iter_next  = '0;
            end
        endcase
        stall_next = (state_next != ST_ACCUM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            iter_reg  <= '0;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            stall_reg <= stall_next;
        end
    end

    assign pixel_stall = stall_reg;

    `ASSERT_HOLDS(a_busy_stalls, clk, rst_n, (state_reg != ST_ACCUM) |-> stall_reg, "input open while busy")
    `ASSERT_NEVER(a_iter_range, clk, rst_n, (state_reg == ST_DIVIDE) && (iter_reg > ITER_W'(NUM_W - 1)), "divide overran")
    `ASSERT_HOLDS(a_last_starts_div, clk, rst_n, (cmd.accept && status.last_pixel) |=> (state_reg == ST_DIVIDE) && (iter_reg == '0), "divide not started on last pixel")

endmodule

// File: sv/prd_datapath.sv
`include "assert_macros.svh"

module prd_datapath #(
    parameter int MAX_RADIUS = prd_pkg::DEF_MAX_RADIUS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [prd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [prd_pkg::PIX_W-1:0]        first_c0,
    input  logic [prd_pkg::PIX_W-1:0]        first_c1,
    input  logic [prd_pkg::PIX_W-1:0]        first_c2,
    input  logic [prd_pkg::PIX_W-1:0]        second_c0,
    input  logic [prd_pkg::PIX_W-1:0]        second_c1,
    input  logic [prd_pkg::PIX_W-1:0]        second_c2,
    input  prd_pkg::cmd_t                    cmd,
    output prd_pkg::status_t                 status,
    input  logic                             rms_stall,
    output logic                             rms_valid,
    output logic [prd_pkg::OUT_W-1:0]        rms_fixed
);

    localparam int EFF_MAX = prd_pkg::eff_max(MAX_RADIUS);
    localparam int PIX_MAX = prd_pkg::pix_max(MAX_RADIUS);
    localparam int CNT_W   = $clog2(PIX_MAX + 1);
    localparam int DIV_W   = $clog2(prd_pkg::NUM_CHANNELS * PIX_MAX + 1);
    localparam int SUM_W   = prd_pkg::sum_w(MAX_RADIUS);
    localparam int NUM_W   = prd_pkg::num_w(MAX_RADIUS);
    localparam int ROOT_W  = prd_pkg::root_w(MAX_RADIUS);
    localparam int RW      = prd_pkg::RADIUS_W;
    localparam int PW      = prd_pkg::PIX_W;
    localparam int SQ_W    = 2 * PW;
    localparam int SQS_W   = SQ_W + 2;

    logic [RW-1:0]        radius_reg;
    logic                 mode_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [DIV_W-1:0]     divisor_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [ROOT_W:0]      srem_reg;
    logic                 out_valid_reg;
    logic [prd_pkg::OUT_W-1:0] out_reg;

    logic [RW-1:0]        eff_r;
    logic [RW:0]          side;
    logic [2*RW+1:0]      side_sq;
    logic [CNT_W-1:0]     pixels;
    logic [DIV_W-1:0]     divisor;
    logic [SQ_W-1:0]      sq0, sq1, sq2;
    logic [SQS_W-1:0]     sq_sum;
    logic [SUM_W-1:0]     sum_final;
    logic                 cfg_hit;
    logic [DIV_W:0]       div_trial;
    logic                 div_ge;
    logic [ROOT_W+2:0]    rt_cand;
    logic [ROOT_W+2:0]    rt_test;
    logic                 rt_ge;
    logic                 out_accept;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [PW-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d * d;
    endfunction

    always_comb
    begin
        eff_r   = (radius_reg > RW'(EFF_MAX)) ? RW'(EFF_MAX) : radius_reg;
        side    = {eff_r, 1'b1};
        side_sq = side * side;
        pixels  = CNT_W'(side_sq);
        // three channels: pixels * 3 as pixels + 2*pixels
        divisor = mode_reg ? (DIV_W'(pixels) + (DIV_W'(pixels) << 1)) : DIV_W'(pixels);

        sq0    = sq_diff(first_c0, second_c0);
        sq1    = sq_diff(first_c1, second_c1);
        sq2    = sq_diff(first_c2, second_c2);
        sq_sum = SQS_W'(sq0);
        if (mode_reg)
        begin
            sq_sum = SQS_W'(sq0) + SQS_W'(sq1) + SQS_W'(sq2);
        end
        sum_final = sum_reg + SUM_W'(sq_sum);

        cfg_hit = cfg_write && ((cfg_index == prd_pkg::REG_WINDOW_RADIUS) ||
                                (cfg_index == prd_pkg::REG_COLOUR_MODE));

        status.last_pixel = ((count_reg + 1'b1) == pixels);
        status.out_free   = !out_valid_reg || !rms_stall;

        // restoring divide, one quotient bit per step
        div_trial = {rem_reg, num_reg[NUM_W-1]};
        div_ge    = (div_trial >= {1'b0, divisor_reg});

        // digit-by-digit root, one bit pair per step
        rt_cand = {srem_reg, num_reg[NUM_W-1:NUM_W-2]};
        rt_test = (ROOT_W+3)'({root_reg, 2'b01});
        rt_ge   = (rt_cand >= rt_test);

        out_accept = out_valid_reg && !rms_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= prd_pkg::RADIUS_RST;
            mode_reg      <= prd_pkg::MODE_RST;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == prd_pkg::REG_WINDOW_RADIUS))
            begin
                radius_reg <= cfg_data[RW-1:0];
            end
            if (cfg_write && (cfg_index == prd_pkg::REG_COLOUR_MODE))
            begin
                mode_reg <= cfg_data[0];
            end

            if (cfg_hit)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else if (cmd.accept)
            begin
                if (status.last_pixel)
                begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    sum_reg   <= sum_final;
                    count_reg <= count_reg + 1'b1;
                end
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && status.last_pixel)
        begin
            num_reg     <= NUM_W'({sum_final, {(2*prd_pkg::FRAC_W){1'b0}}});
            rem_reg     <= '0;
            divisor_reg <= divisor;
            root_reg    <= '0;
            srem_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], div_ge};
            rem_reg <= div_ge ? DIV_W'(div_trial - {1'b0, divisor_reg}) : DIV_W'(div_trial);
        end
        else if (cmd.root_step)
        begin
            num_reg  <= {num_reg[NUM_W-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_W-2:0], rt_ge};
            srem_reg <= rt_ge ? (ROOT_W+1)'(rt_cand - rt_test) : (ROOT_W+1)'(rt_cand);
        end

        if (cmd.load_out)
        begin
            out_reg <= root_reg[prd_pkg::OUT_W-1:0];
        end
    end

    assign rms_valid = out_valid_reg;
    assign rms_fixed = out_reg;

    `ASSERT_HOLDS(a_count_in_window, clk, rst_n, count_reg < pixels, "pixel count past window")
    `ASSERT_NEVER(a_divisor_zero, clk, rst_n, cmd.div_step && (divisor_reg == '0), "divide by zero")
    `ASSERT_NEVER(a_out_overwrite, clk, rst_n, cmd.load_out && out_valid_reg && rms_stall, "result overwritten")

endmodule

// File: tb/patch_rms_difference_tb.sv
`timescale 1ns / 1ps

module patch_rms_difference_tb;

    localparam int PIX_W      = prd_pkg::PIX_W;
    localparam int OUT_W      = prd_pkg::OUT_W;
    localparam int RADIUS_W   = prd_pkg::RADIUS_W;
    localparam int CFG_IDX_W  = prd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = prd_pkg::CFG_DATA_W;

    localparam prd_pkg::cfg_reg_t REG_WINDOW_RADIUS = prd_pkg::REG_WINDOW_RADIUS;
    localparam prd_pkg::cfg_reg_t REG_COLOUR_MODE   = prd_pkg::REG_COLOUR_MODE;

    localparam int MAX_R         = prd_pkg::DEF_MAX_RADIUS;
    localparam int RANDOM_ITEMS  = 900;
    localparam int SETTLE_CYCLES = 100;
    localparam int LONG_HOLD     = 400;

    // indexes past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam logic [OUT_W-1:0]     RMS_FULL     = 16'd65280;

    // layout {f0 f1 f2 s0 s1 s2}, first patch in the upper half
    typedef struct packed {
        logic [PIX_W-1:0] f0;
        logic [PIX_W-1:0] f1;
        logic [PIX_W-1:0] f2;
        logic [PIX_W-1:0] s0;
        logic [PIX_W-1:0] s1;
        logic [PIX_W-1:0] s2;
    } pixel_pair_t;

    localparam pixel_pair_t NO_PIXEL = '0;

    typedef enum logic {ROW_PIXEL, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        pixel_pair_t           pix;
        int                    reps;
        bit                    given;
        logic [OUT_W-1:0]      given_rms;
    } stim_row_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_stall;
    logic [PIX_W-1:0]      first_c0    = '0;
    logic [PIX_W-1:0]      first_c1    = '0;
    logic [PIX_W-1:0]      first_c2    = '0;
    logic [PIX_W-1:0]      second_c0   = '0;
    logic [PIX_W-1:0]      second_c1   = '0;
    logic [PIX_W-1:0]      second_c2   = '0;
    logic                  rms_valid;
    logic                  rms_stall   = 1'b0;
    logic [OUT_W-1:0]      rms_fixed;

    // mirror of the block's registers and accumulators
    logic [RADIUS_W-1:0]   radius_mirror = prd_pkg::RADIUS_RST;
    logic                  colour_mirror = prd_pkg::MODE_RST;
    longint unsigned       diff_sq_sum   = 0;
    int unsigned           pixels_seen   = 0;

    logic [OUT_W-1:0]      rms_expected [$];
    logic [OUT_W-1:0]      rms_want;
    int                    fail_count    = 0;
    int unsigned           burst_left    = 0;
    int unsigned           gap_max       = 0;
    int unsigned           stall_pct     = 0;
    bit                    hold_pending  = 1'b0;
    stim_row_t             directed_rows [16];

    always #6 clk = ~clk;

    patch_rms_difference #(
        .MAX_RADIUS (MAX_R)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .first_c0    (first_c0),
        .first_c1    (first_c1),
        .first_c2    (first_c2),
        .second_c0   (second_c0),
        .second_c1   (second_c1),
        .second_c2   (second_c2),
        .rms_valid   (rms_valid),
        .rms_stall   (rms_stall),
        .rms_fixed   (rms_fixed)
    );

    function automatic longint unsigned sq_gap(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        longint unsigned d;
        d = (a > b) ? longint'(a) - longint'(b) : longint'(b) - longint'(a);
        return d * d;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        if (idx == REG_WINDOW_RADIUS)
            radius_mirror = data[RADIUS_W-1:0];
        else if (idx == REG_COLOUR_MODE)
            colour_mirror = data[0];
        else
            return;
        diff_sq_sum = 0;
        pixels_seen = 0;
    endfunction

    // accumulate one pixel pair; at the window end queue the rms
    function automatic void accumulate_pixel(input pixel_pair_t p, input bit given,
                                             input logic [OUT_W-1:0] given_rms);
        int unsigned     r;
        int unsigned     pixels;
        int unsigned     chans;
        longint unsigned mean_scaled;
        r      = (radius_mirror > MAX_R) ? MAX_R : radius_mirror;
        pixels = (2 * r + 1) * (2 * r + 1);
        chans  = colour_mirror ? 3 : 1;
        diff_sq_sum += sq_gap(p.f0, p.s0);
        if (colour_mirror)
            diff_sq_sum += sq_gap(p.f1, p.s1) + sq_gap(p.f2, p.s2);
        pixels_seen++;
        if (pixels_seen >= pixels)
        begin
            mean_scaled = (diff_sq_sum << 16) / longint'(pixels * chans);
            rms_expected.push_back(given ? given_rms : OUT_W'(floor_sqrt(mean_scaled)));
            diff_sq_sum = 0;
            pixels_seen = 0;
        end
    endfunction

    function automatic pixel_pair_t rand_pixel();
        pixel_pair_t p;
        p = {$urandom, 16'($urandom)};
        case ($urandom_range(0, 3))
            1:
            begin
                p.s0 = p.f0 + PIX_W'($urandom_range(0, 6)) - 8'd3;
                p.s1 = p.f1 + PIX_W'($urandom_range(0, 6)) - 8'd3;
                p.s2 = p.f2 + PIX_W'($urandom_range(0, 6)) - 8'd3;
            end
            2:
            begin
                p.f0 = {PIX_W{p.f0[0]}};
                p.f1 = {PIX_W{p.f1[0]}};
                p.f2 = {PIX_W{p.f2[0]}};
                p.s0 = {PIX_W{p.s0[0]}};
                p.s1 = {PIX_W{p.s1[0]}};
                p.s2 = {PIX_W{p.s2[0]}};
            end
            3:
            begin
                p.s0 = p.f0;
                p.s1 = p.f1;
                p.s2 = p.f2;
            end
            default: ;
        endcase
        return p;
    endfunction

    // drop valid and wait until the block has drained
    task automatic settle();
        pixel_valid <= 1'b0;
        burst_left = 0;
        while (rms_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic offer_pixel(input pixel_pair_t p, input bit given,
                               input logic [OUT_W-1:0] given_rms);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                pixel_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        pixel_valid <= 1'b1;
        first_c0    <= p.f0;
        first_c1    <= p.f1;
        first_c2    <= p.f2;
        second_c0   <= p.s0;
        second_c1   <= p.s1;
        second_c2   <= p.s2;
        do
            @(posedge clk);
        while (pixel_stall !== 1'b0);
        accumulate_pixel(p, given, given_rms);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rms_valid && !rms_stall)
        begin
            if (rms_expected.size() == 0)
            begin
                $error("rms_fixed: no result expected, got %0d", rms_fixed);
                fail_count++;
            end
            else
            begin
                rms_want = rms_expected.pop_front();
                if (rms_fixed !== rms_want)
                begin
                    $error("rms_fixed: expected %0d, got %0d", rms_want, rms_fixed);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                rms_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                rms_stall <= 1'b1;
                repeat ($urandom_range(0, 4)) @(posedge clk);
            end
            else
            begin
                rms_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("FAIL patch_rms_difference");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned r;
        int unsigned pix;
        int unsigned n;
        int unsigned spread;
        int unsigned spare_at;
        int unsigned pixels_sent;

        directed_rows = '{
            // reset state: 3x3 window, colour
            '{ROW_PIXEL, REG_WINDOW_RADIUS, 4'd0, 48'hFFFFFF_000000, 9, 1'b1, RMS_FULL},
            '{ROW_CFG,   REG_WINDOW_RADIUS, 4'd0, NO_PIXEL,          1, 1'b0, 16'd0},
            '{ROW_PIXEL, REG_WINDOW_RADIUS, 4'd0, 48'h000000_000000, 1, 1'b1, 16'd0},
            '{ROW_PIXEL, REG_WINDOW_RADIUS, 4'd0, 48'h000000_FFFFFF, 1, 1'b1, RMS_FULL},
            // only bit 0 counts: grey
            '{ROW_CFG,   REG_COLOUR_MODE,   4'hE, NO_PIXEL,          1, 1'b0, 16'd0},
            '{ROW_PIXEL, REG_WINDOW_RADIUS, 4'd0, 48'h10FF00_1000FF, 1, 1'b1, 16'd0},
            '{ROW_PIXEL, REG_WINDOW_RADIUS, 4'd0, 48'h000000_010000, 1, 1'b1, 16'd256},
            '{ROW_CFG,   REG_WINDOW_RADIUS, 4'd1, NO_PIXEL,          1, 1'b0, 16'd0},
            '{ROW_PIXEL, REG_WINDOW_RADIUS, 4'd0, 48'hAA5533_123456, 4, 1'b0, 16'd0},
            // ignored write, window carries on
            '{ROW_CFG,   REG_SPARE_HI,      4'hF, NO_PIXEL,          1, 1'b0, 16'd0},
            '{ROW_PIXEL, REG_WINDOW_RADIUS, 4'd0, 48'h7F8001_807FFE, 5, 1'b0, 16'd0},
            '{ROW_PIXEL, REG_WINDOW_RADIUS, 4'd0, 48'hFF0000_000000, 2, 1'b0, 16'd0},
            // restarts the partial window
            '{ROW_CFG,   REG_WINDOW_RADIUS, 4'd0, NO_PIXEL,          1, 1'b0, 16'd0},
            '{ROW_PIXEL, REG_WINDOW_RADIUS, 4'd0, 48'h000000_030000, 1, 1'b1, 16'd768},
            '{ROW_CFG,   REG_COLOUR_MODE,   4'd1, NO_PIXEL,          1, 1'b0, 16'd0},
            '{ROW_PIXEL, REG_WINDOW_RADIUS, 4'd0, 48'hFF00FF_00FF00, 1, 1'b1, RMS_FULL}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stall_pct = 30;
        gap_max   = 3;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            else
                repeat (directed_rows[i].reps)
                    offer_pixel(directed_rows[i].pix, directed_rows[i].given,
                                directed_rows[i].given_rms);
        end

        // widest window at full difference: largest sum the block can hold
        write_reg(REG_WINDOW_RADIUS, CFG_DATA_W'(prd_pkg::RADIUS_LIMIT));
        stall_pct = 20;
        gap_max   = 2;
        repeat ((2 * MAX_R + 1) * (2 * MAX_R + 1))
            offer_pixel(48'hFFFFFF_000000, 1'b0, '0);

        // receiver holds off while one-pixel windows keep coming
        write_reg(REG_WINDOW_RADIUS, '0);
        stall_pct    = 0;
        gap_max      = 0;
        hold_pending = 1'b1;
        repeat (40) offer_pixel(rand_pixel(), 1'b0, '0);

        pixels_sent = 0;
        while (pixels_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: r = 0;
                3, 4, 5: r = 1;
                6, 7:    r = 2;
                8:       r = $urandom_range(3, 4);
                default: r = $urandom_range(5, 7);
            endcase
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_WINDOW_RADIUS, CFG_DATA_W'(r));
                if ($urandom_range(0, 1))
                    write_reg(REG_COLOUR_MODE, CFG_DATA_W'($urandom));
            end
            else
            begin
                write_reg(REG_COLOUR_MODE, CFG_DATA_W'($urandom));
                if ($urandom_range(0, 1))
                    write_reg(REG_WINDOW_RADIUS, CFG_DATA_W'(r));
            end
            // radius may be left from before when its write was skipped
            r = radius_mirror;

            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 15;
                default: stall_pct = 50;
            endcase
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 2;
                default: gap_max = 6;
            endcase

            pix    = (2 * r + 1) * (2 * r + 1);
            spread = (60 / pix > 1) ? 60 / pix : 1;
            n      = pix * $urandom_range(1, spread);
            // trailing partial window, cleared by the next write
            if (pix > 1 && $urandom_range(0, 3) == 0)
                n += $urandom_range(1, pix - 1);
            spare_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : n;

            for (int i = 0; i < n; i++)
            begin
                if (i == spare_at)
                    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                              CFG_DATA_W'($urandom));
                offer_pixel(rand_pixel(), 1'b0, '0);
                pixels_sent++;
            end
        end

        settle();
        if (fail_count == 0 && rms_expected.size() == 0)
            $display("PASS patch_rms_difference");
        else
            $display("FAIL patch_rms_difference");
        $finish;
    end

endmodule

// File: patch_rms_difference.f
+incdir+sv
sv/prd_pkg.sv
sv/prd_ctrl.sv
sv/prd_datapath.sv
sv/patch_rms_difference.sv
tb/patch_rms_difference_tb.sv
